// ===== rtl/core/mstf_pkg.sv =====
// Shared types and constants for the max segment tree search block.
// No dependencies; imported by every module of the block.
package mstf_pkg;

  localparam int SZ_W              = 11;
  localparam int VAL_W             = 32;
  localparam int NODE_W            = 13;
  localparam int DEF_MAX_POSITIONS = 1024;
  localparam int DEF_NODE_COUNT    = 4096;
  localparam int STK_DEPTH         = 16;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_DESC,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SRCH_RD,
    ST_SRCH_EVAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [SZ_W-1:0]   lo;
    logic [SZ_W-1:0]   hi;
  } stk_entry_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

// ===== rtl/core/mstf_stack.sv =====
// Pending-node stack for the depth-first search walk.
// Depends on mstf_pkg for the entry and control types.
module mstf_stack #(
  parameter int DEPTH = mstf_pkg::STK_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mstf_pkg::stk_ctrl_t ctrl,
  input  mstf_pkg::stk_entry_t push_entry,
  output mstf_pkg::stk_entry_t top_entry,
  output logic                empty
);
  import mstf_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = IW + 1;

  stk_entry_t      entries_r [DEPTH];
  logic [PW-1:0]   ptr_r;
  logic [PW-1:0]   ptr_nxt;
  logic [PW-1:0]   top_ptr;

  assign top_ptr   = ptr_r - PW'(1);
  assign top_entry = entries_r[top_ptr[IW-1:0]];
  assign empty     = (ptr_r == '0);

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctrl.clear) begin
      ptr_nxt = '0;
    end else if (ctrl.push) begin
      ptr_nxt = ptr_r + PW'(1);
    end else if (ctrl.pop) begin
      ptr_nxt = top_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      entries_r[ptr_r[IW-1:0]] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/max_segment_tree_first_at_least.sv =====
// Channel | handshake        | payload
// in      | in_valid/ready   | in_opcode, in_position, in_value
// out     | out_valid/ready  | out_found, out_found_position
// cfg     | cfg_wr_en        | cfg_wr_data (size_in_use)
//
// After reset a sweep zeroes the node memory; in_ready stays low.
// An update holds in_ready low while it walks a tree of depth D (10 for 1024 positions):
// it descends one level at a time, writes the leaf, then reads the sibling and writes the
// parent at each level up.
// A search reads and then evaluates each visited node through the single memory read
// port, then emits the result. A result still waiting in the output register
// holds the next search at its result step.
// Depends on mstf_pkg and mstf_stack.
module max_segment_tree_first_at_least #(
  parameter int MAX_POSITIONS = mstf_pkg::DEF_MAX_POSITIONS,
  parameter int NODE_COUNT    = mstf_pkg::DEF_NODE_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [mstf_pkg::SZ_W-1:0]         in_position,
  input  logic signed [mstf_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [mstf_pkg::SZ_W-1:0]         out_found_position,
  input  logic                              cfg_wr_en,
  input  logic [mstf_pkg::SZ_W-1:0]         cfg_wr_data
);
  import mstf_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return int'(n) < NODE_COUNT;
  endfunction

  logic signed [VAL_W-1:0] mem [NODE_COUNT];

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           clr_addr_r, clr_addr_nxt;
  logic [SZ_W-1:0]         size_r;
  logic [NODE_W-1:0]       node_r, node_nxt;
  logic [SZ_W-1:0]         lo_r, lo_nxt;
  logic [SZ_W-1:0]         hi_r, hi_nxt;
  logic [SZ_W-1:0]         pos_r, pos_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [VAL_W-1:0] cur_r, cur_nxt;
  logic signed [VAL_W-1:0] rd_data_r;
  logic                    rd_ok_r, rd_ok_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [SZ_W-1:0]         res_pos_r, res_pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [SZ_W-1:0]         out_pos_r, out_pos_nxt;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;

  logic [SZ_W-1:0]         eff_size;
  logic [SZ_W:0]           mid_sum;
  logic [SZ_W-1:0]         mid;
  logic [NODE_W-1:0]       left_node, right_node, sib_node, par_node;
  logic signed [VAL_W-1:0] node_val, max_val;
  logic                    in_xfer;

  stk_ctrl_t               stk_ctrl;
  stk_entry_t              stk_push, stk_top;
  logic                    stk_empty;

  mstf_stack #(
    .DEPTH (STK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (stk_ctrl),
    .push_entry (stk_push),
    .top_entry  (stk_top),
    .empty      (stk_empty)
  );

  assign in_ready           = (state_r == ST_IDLE);
  assign in_xfer            = in_valid && in_ready;
  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_pos_r;

  always_comb begin
    if (size_r == '0) begin
      eff_size = SZ_W'(1);
    end else if (int'(size_r) > MAX_POSITIONS) begin
      eff_size = SZ_W'(MAX_POSITIONS);
    end else begin
      eff_size = size_r;
    end
  end

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[SZ_W:1];
  assign left_node  = {node_r[NODE_W-2:0], 1'b0};
  assign right_node = {node_r[NODE_W-2:0], 1'b1};
  assign sib_node   = {node_r[NODE_W-1:1], ~node_r[0]};
  assign par_node   = {1'b0, node_r[NODE_W-1:1]};
  assign node_val   = rd_ok_r ? rd_data_r : VAL_MIN;
  assign max_val    = (cur_r > node_val) ? cur_r : node_val;
  assign stk_push   = '{node: right_node, lo: mid + SZ_W'(1), hi: hi_r};

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    node_nxt      = node_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    rd_ok_nxt     = rd_ok_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(node_r);
    mem_wdata     = val_r;
    mem_re        = 1'b0;
    mem_raddr     = AW'(node_r);
    stk_ctrl      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          node_nxt = NODE_W'(1);
          lo_nxt   = SZ_W'(1);
          hi_nxt   = eff_size;
          pos_nxt  = in_position;
          val_nxt  = in_value;
          if (op_t'(in_opcode) == OP_SEARCH) begin
            stk_ctrl.clear = 1'b1;
            state_nxt      = ST_SRCH_RD;
          end else if (in_position != '0 && in_position <= eff_size) begin
            state_nxt = ST_UPD_DESC;
          end
        end
      end
      ST_UPD_DESC: begin
        if (lo_r == hi_r) begin
          mem_we  = node_ok(node_r);
          cur_nxt = node_ok(node_r) ? val_r : VAL_MIN;
          state_nxt = (node_r == NODE_W'(1)) ? ST_IDLE : ST_UPD_RD;
        end else if (pos_r <= mid) begin
          node_nxt = left_node;
          hi_nxt   = mid;
        end else begin
          node_nxt = right_node;
          lo_nxt   = mid + SZ_W'(1);
        end
      end
      ST_UPD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(sib_node);
        rd_ok_nxt = node_ok(sib_node);
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        mem_we    = node_ok(par_node);
        mem_waddr = AW'(par_node);
        mem_wdata = max_val;
        cur_nxt   = node_ok(par_node) ? max_val : VAL_MIN;
        node_nxt  = par_node;
        state_nxt = (par_node == NODE_W'(1)) ? ST_IDLE : ST_UPD_RD;
      end
      ST_SRCH_RD: begin
        mem_re    = 1'b1;
        rd_ok_nxt = node_ok(node_r);
        state_nxt = ST_SRCH_EVAL;
      end
      ST_SRCH_EVAL: begin
        if (hi_r < pos_r || node_val < val_r) begin
          if (stk_empty) begin
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = ST_EMIT;
          end else begin
            stk_ctrl.pop = 1'b1;
            node_nxt     = stk_top.node;
            lo_nxt       = stk_top.lo;
            hi_nxt       = stk_top.hi;
            state_nxt    = ST_SRCH_RD;
          end
        end else if (lo_r == hi_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = lo_r;
          state_nxt     = ST_EMIT;
        end else begin
          stk_ctrl.push = 1'b1;
          node_nxt      = left_node;
          hi_nxt        = mid;
          state_nxt     = ST_SRCH_RD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      size_r      <= SZ_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    cur_r       <= cur_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

// ===== rtl/core/mstf_checker.sv =====
// Port-level checks for max_segment_tree_first_at_least, bound to the top level.
// Depends on mstf_pkg for field widths.
module mstf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_found,
  input logic [mstf_pkg::SZ_W-1:0]         out_found_position
);
  import mstf_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_found_position))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_position == '0)
    else $error("miss with nonzero position");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_found_position != '0)
    else $error("hit at position zero");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result right after input transfer");

endmodule

bind max_segment_tree_first_at_least mstf_checker u_mstf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_found          (out_found),
  .out_found_position (out_found_position)
);

// ===== verif/max_segment_tree_first_at_least_tb.sv =====
// Testbench for max_segment_tree_first_at_least: drives writes and searches, predicts each
// search answer with a local max segment tree, and compares every result transfer.
// Depends on mstf_pkg and the block's RTL.
module max_segment_tree_first_at_least_tb;
  import mstf_pkg::*;

  localparam int NODES        = DEF_NODE_COUNT;
  localparam int MAXPOS       = DEF_MAX_POSITIONS;
  localparam int SETTLE       = 200;
  localparam int TAIL_CYCLES  = 300;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 1200000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic            found;
    logic [SZ_W-1:0] found_position;
  } answer_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_opcode = 1'b0;
  logic [SZ_W-1:0]          in_position = '0;
  logic signed [VAL_W-1:0]  in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_found;
  logic [SZ_W-1:0]          out_found_position;
  logic                     cfg_wr_en = 1'b0;
  logic [SZ_W-1:0]          cfg_wr_data = '0;

  logic signed [VAL_W-1:0]  tree_nodes [NODES];
  logic [SZ_W-1:0]          size_reg;
  answer_t                  search_answers [$];
  answer_t                  head_answer;
  bit                       idle_mode = 1'b0;
  int                       hold_requests = 0;
  int                       hold_served = 0;
  int                       hold_left = 0;
  int                       gap_left = 0;
  int                       fails = 0;
  int                       cycles = 0;

  max_segment_tree_first_at_least dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int span();
    if (size_reg == 0) return 1;
    if (size_reg > MAXPOS) return MAXPOS;
    return int'(size_reg);
  endfunction

  function automatic logic signed [VAL_W-1:0] node_at(input int n);
    if (n >= NODES) return VAL_MIN;
    return tree_nodes[n];
  endfunction

  function automatic void tree_store(input int pos, input logic signed [VAL_W-1:0] val);
    int n;
    int lo;
    int hi;
    int mid;
    int path [$];
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    n = 1;
    lo = 1;
    hi = span();
    if (pos < 1 || pos > hi) return;
    while (lo != hi) begin
      path.push_back(n);
      mid = (lo + hi) >> 1;
      if (pos <= mid) begin
        n = 2 * n;
        hi = mid;
      end else begin
        n = 2 * n + 1;
        lo = mid + 1;
      end
    end
    if (n < NODES) tree_nodes[n] = val;
    while (path.size() != 0) begin
      n = path.pop_back();
      a = node_at(2 * n);
      b = node_at(2 * n + 1);
      if (n < NODES) tree_nodes[n] = (a > b) ? a : b;
    end
  endfunction

  // Depth-first, left subtree first; returns 0 when nothing qualifies.
  function automatic int first_at_least(input int start, input logic signed [VAL_W-1:0] thr);
    int stk_n [$];
    int stk_lo [$];
    int stk_hi [$];
    int n;
    int lo;
    int hi;
    int mid;
    stk_n.push_back(1);
    stk_lo.push_back(1);
    stk_hi.push_back(span());
    while (stk_n.size() != 0) begin
      n = stk_n.pop_back();
      lo = stk_lo.pop_back();
      hi = stk_hi.pop_back();
      if (hi < start || node_at(n) < thr) continue;
      if (lo == hi) return lo;
      mid = (lo + hi) >> 1;
      stk_n.push_back(2 * n + 1);
      stk_lo.push_back(mid + 1);
      stk_hi.push_back(hi);
      stk_n.push_back(2 * n);
      stk_lo.push_back(lo);
      stk_hi.push_back(mid);
    end
    return 0;
  endfunction

  function automatic int pick_position(input int s);
    case ($urandom_range(0, 19))
      0: return 0;
      1: return s + 1;
      2: return $urandom_range(0, 2047);
      3: return s;
      default: return $urandom_range(1, s);
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MIN + 32'sd1;
        2: return -32'sd1;
        3: return 32'sd0;
        4: return VAL_MAX - 32'sd1;
        default: return VAL_MAX;
      endcase
    end
    if (r < 7) return $urandom;
    return $signed($urandom_range(0, 80)) - 32'sd40;
  endfunction

  // Result side: check each transfer, then drive out_ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (search_answers.size() == 0) begin
        $error("unexpected result: found=%0b found_position=%0d", out_found,
               out_found_position);
        fails++;
      end else begin
        head_answer = search_answers.pop_front();
        if (out_found !== head_answer.found) begin
          $error("found: expected %0b, actual %0b", head_answer.found, out_found);
          fails++;
        end
        if (out_found_position !== head_answer.found_position) begin
          $error("found_position: expected %0d, actual %0d", head_answer.found_position,
                 out_found_position);
          fails++;
        end
      end
    end
    if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      out_ready <= 1'b0;
    end else if (idle_mode && $urandom_range(0, 4) == 0) begin
      gap_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input op_t op, input int pos, input logic signed [VAL_W-1:0] val);
    int r;
    answer_t a;
    if (idle_mode && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_position <= pos[SZ_W-1:0];
    in_value <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (op == OP_SEARCH) begin
      r = first_at_least(pos, val);
      a.found = (r != 0);
      a.found_position = r[SZ_W-1:0];
      search_answers.push_back(a);
    end else begin
      tree_store(pos, val);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (search_answers.size() != 0);
  endtask

  task automatic set_size(input int v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[SZ_W-1:0];
    size_reg = v[SZ_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_mixed(input int size_cfg, input int n_items, input bit idle_ok);
    int s;
    int p;
    int i;
    op_t op;
    set_size(size_cfg);
    s = span();
    // load the array one position at a time, a window of it for big trees
    for (p = 1; p <= s && p <= 48; p++) send_item(OP_WRITE, p, pick_value());
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) idle_mode <= idle_ok && ($urandom_range(0, 3) != 0);
      if (idle_ok && $urandom_range(0, 59) == 0) wait_drained();
      op = ($urandom_range(0, 9) < 6) ? OP_SEARCH : OP_WRITE;
      send_item(op, pick_position(s), pick_value());
    end
  endtask

  task automatic test_one_element();
    set_size(0);
    send_item(OP_SEARCH, 1, 32'sd0);
    send_item(OP_SEARCH, 1, 32'sd1);
    send_item(OP_WRITE, 1, VAL_MIN);
    send_item(OP_SEARCH, 0, VAL_MIN);
    send_item(OP_SEARCH, 1, VAL_MIN + 32'sd1);
    send_item(OP_WRITE, 0, VAL_MAX);
    send_item(OP_WRITE, 2, VAL_MAX);
    send_item(OP_SEARCH, 2, VAL_MIN);
    send_item(OP_SEARCH, 1, 32'sd0);
    send_item(OP_WRITE, 1, VAL_MAX);
    send_item(OP_SEARCH, 1, VAL_MAX);
  endtask

  task automatic test_extremes();
    set_size(2047);
    send_item(OP_WRITE, 1024, VAL_MAX);
    send_item(OP_WRITE, 1, VAL_MIN);
    send_item(OP_WRITE, 512, -32'sd1);
    send_item(OP_WRITE, 2047, VAL_MAX);
    send_item(OP_WRITE, 1025, 32'sd5);
    send_item(OP_SEARCH, 0, VAL_MAX);
    send_item(OP_SEARCH, 1, -32'sd1);
    send_item(OP_SEARCH, 1025, VAL_MIN);
    send_item(OP_SEARCH, 2047, VAL_MIN);
    send_item(OP_SEARCH, 1024, VAL_MIN);
    send_item(OP_SEARCH, 513, 32'sd1);
    send_item(OP_SEARCH, 1, VAL_MIN);
  endtask

  // Size changes keep the node store as it stands.
  task automatic test_random_sizes();
    int sizes [10];
    int k;
    sizes = '{2, 3, 7, 16, 33, 100, 0, 1024, 1000, 5};
    for (k = 0; k < 10; k++) run_mixed(sizes[k], 110, 1'b1);
  endtask

  task automatic test_backpressure();
    int i;
    set_size(50);
    idle_mode <= 1'b0;
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 60; i++) send_item(OP_SEARCH, pick_position(50), pick_value());
    wait_drained();
  endtask

  task automatic test_no_idle_stream();
    run_mixed($urandom_range(1, 300), 220, 1'b0);
  endtask

  initial begin
    foreach (tree_nodes[n]) tree_nodes[n] = '0;
    size_reg = SZ_W'(1);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_one_element();
    test_extremes();
    test_random_sizes();
    test_backpressure();
    test_no_idle_stream();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (search_answers.size() != 0) begin
      $error("%0d search results never arrived", search_answers.size());
      fails++;
    end
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== max_segment_tree_first_at_least.f =====
rtl/core/mstf_pkg.sv
rtl/core/mstf_stack.sv
rtl/core/max_segment_tree_first_at_least.sv
rtl/core/mstf_checker.sv
verif/max_segment_tree_first_at_least_tb.sv
